>>> rtl/yay0_pkg.sv
`default_nettype none

package yay0_pkg;

  // item kinds, also used for the next_need result field
  typedef enum logic [2:0] {
    KindStart = 3'd0,
    KindFlag  = 3'd1,
    KindLink  = 3'd2,
    KindChunk = 3'd3,
    KindTick  = 3'd4
  } kind_e;

  // result status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatBadKind = 2'd1;
  localparam logic [1:0] StatFar     = 2'd2;

  // link and flag format constants
  localparam int unsigned FlagCount    = 32;
  localparam int unsigned LinkDistBits = 12;
  localparam logic [8:0]  ShortLenBias = 9'd2;
  localparam logic [8:0]  LongLenBias  = 9'd18;

endpackage

`default_nettype wire

>>> rtl/yay0_hist.sv
`default_nettype none

module yay0_hist #(
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [7:0]               wr_data_i,
  output logic      [7:0]               rd_data_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;
  logic [7:0] byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // a read that meets a write to the same entry takes the new byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i[AddrW-1:0]);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

>>> rtl/yay0_lz_decompressor.sv
`default_nettype none

// Yay0 LZ decompressor. The feeder sends a start item, then flag words, link
// words and chunk bytes as next_need asks for them, and one copy tick per byte
// of a back-reference. Every accepted item gives exactly one result item with
// the produced byte (if any), the kind wanted next, a finished flag and a
// status (ok, unexpected kind ignored, distance reaching before the stream
// start). Output stops exactly at out_size bytes. Throughput is one item per
// clock, copy ticks included, unless the result side stalls: control state
// is updated at accept, the 4096-byte history ring is read at accept and
// written as the byte leaves the second stage, and a bypass covers a read of
// the entry being written (distance 1). The result register lets the next
// item enter while a result waits. The user writes out_size through its own
// port only while the block is idle; the block itself does not enforce it.

module yay0_lz_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned COUNT_BITS   = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [23:0] out_size_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] value_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  out_byte_o,
  output logic             byte_valid_o,
  output logic      [2:0]  next_need_o,
  output logic             finished_o,
  output logic      [1:0]  status_o
);

  localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
  localparam int unsigned CmpW = (COUNT_BITS > AW + 1) ? COUNT_BITS : AW + 1;

  // stream state
  logic [COUNT_BITS-1:0] out_size_q;
  logic [COUNT_BITS-1:0] produced_q, produced_d;
  logic [31:0]           flag_bits_q, flag_bits_d;
  logic [5:0]            flags_left_q, flags_left_d;
  logic [8:0]            copy_left_q, copy_left_d;
  logic [AW:0]           copy_dist_q, copy_dist_d;
  yay0_pkg::kind_e       expect_q, expect_d;

  // second stage: byte being resolved and written to history
  logic          s1_valid_q;
  logic          s1_emit_q, s1_emit_d;
  logic          s1_lit_q, s1_lit_d;
  logic [7:0]    s1_lit_byte_q;
  logic [AW-1:0] s1_waddr_q;
  logic [2:0]    s1_need_q;
  logic          s1_fin_q, s1_fin_d;
  logic [1:0]    s1_status_q, s1_status_d;
  logic [7:0]    s1_byte;

  // result register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       byte_valid_q;
  logic [2:0] next_need_q;
  logic       finished_q;
  logic [1:0] status_q;

  logic          in_fire, s1_adv;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    hist_rdata;
  logic [AW:0]   link_dist;
  logic [3:0]    link_nib;
  logic          link_far;
  logic [COUNT_BITS-1:0] produced_inc;
  logic          done_inc;
  logic          done_new;
  logic          do_adv;
  logic [31:0]   cfg_ext;

  // the result stage frees the second stage; the second stage frees the input
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = {8'd0, out_size_i};

  assign link_dist    = {1'b0, value_i[yay0_pkg::LinkDistBits-1:0]} + (AW+1)'(1);
  assign link_nib     = value_i[15:12];
  assign link_far     = CmpW'(produced_q) < CmpW'(link_dist);
  assign produced_inc = produced_q + COUNT_BITS'(1);
  assign done_inc     = produced_inc >= out_size_q;

  // source byte for a copy: produced - distance, wrapped on the ring
  assign rd_addr = produced_q[AW-1:0] - copy_dist_q[AW-1:0];

  always_comb begin
    produced_d   = produced_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    copy_left_d  = copy_left_q;
    copy_dist_d  = copy_dist_q;
    expect_d     = expect_q;
    s1_status_d  = yay0_pkg::StatOk;
    s1_emit_d    = 1'b0;
    s1_lit_d     = 1'b0;
    rd_en        = 1'b0;
    do_adv       = 1'b0;

    if (kind_i == yay0_pkg::KindStart) begin
      // restart, aborting whatever was in progress
      produced_d   = '0;
      flag_bits_d  = '0;
      flags_left_d = '0;
      do_adv       = 1'b1;
    end else if (kind_i != expect_q) begin
      s1_status_d = yay0_pkg::StatBadKind;
    end else begin
      case (expect_q)
        yay0_pkg::KindFlag: begin
          flag_bits_d  = value_i;
          flags_left_d = 6'(yay0_pkg::FlagCount);
          do_adv       = 1'b1;
        end
        yay0_pkg::KindLink: begin
          if (link_far) begin
            s1_status_d = yay0_pkg::StatFar;
          end else begin
            flag_bits_d = {flag_bits_q[30:0], 1'b0};
            if (flags_left_q != 6'd0) begin
              flags_left_d = flags_left_q - 6'd1;
            end
            copy_dist_d = link_dist;
            if (link_nib == 4'd0) begin
              // long form: the length follows as a chunk byte
              expect_d = yay0_pkg::KindChunk;
            end else begin
              copy_left_d = {5'd0, link_nib} + yay0_pkg::ShortLenBias;
              expect_d    = yay0_pkg::KindTick;
            end
          end
        end
        yay0_pkg::KindChunk: begin
          if (copy_dist_q != '0) begin
            copy_left_d = {1'b0, value_i[7:0]} + yay0_pkg::LongLenBias;
            expect_d    = yay0_pkg::KindTick;
          end else begin
            // literal byte
            s1_emit_d   = 1'b1;
            s1_lit_d    = 1'b1;
            produced_d  = produced_inc;
            flag_bits_d = {flag_bits_q[30:0], 1'b0};
            if (flags_left_q != 6'd0) begin
              flags_left_d = flags_left_q - 6'd1;
            end
            do_adv = 1'b1;
          end
        end
        yay0_pkg::KindTick: begin
          s1_emit_d  = 1'b1;
          rd_en      = in_fire;
          produced_d = produced_inc;
          if (copy_left_q != 9'd0) begin
            copy_left_d = copy_left_q - 9'd1;
          end
          do_adv = done_inc || (copy_left_d == 9'd0);
        end
        default: begin
        end
      endcase
    end

    done_new = produced_d >= out_size_q;

    // pick the next item once a flag bit is fully handled
    if (do_adv) begin
      copy_left_d = '0;
      copy_dist_d = '0;
      if (done_new) begin
        expect_d = yay0_pkg::KindStart;
      end else if (flags_left_d == 6'd0) begin
        expect_d = yay0_pkg::KindFlag;
      end else if (flag_bits_d[31]) begin
        expect_d = yay0_pkg::KindChunk;
      end else begin
        expect_d = yay0_pkg::KindLink;
      end
    end

    s1_fin_d = (expect_d == yay0_pkg::KindStart) && done_new;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_size_q   <= '0;
      produced_q   <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      copy_left_q  <= '0;
      copy_dist_q  <= '0;
      expect_q     <= yay0_pkg::KindStart;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        out_size_q <= cfg_ext[COUNT_BITS-1:0];
      end
      if (in_fire) begin
        produced_q   <= produced_d;
        flag_bits_q  <= flag_bits_d;
        flags_left_q <= flags_left_d;
        copy_left_q  <= copy_left_d;
        copy_dist_q  <= copy_dist_d;
        expect_q     <= expect_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload of the two stages
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_emit_q     <= s1_emit_d;
      s1_lit_q      <= s1_lit_d;
      s1_lit_byte_q <= value_i[7:0];
      s1_waddr_q    <= produced_q[AW-1:0];
      s1_need_q     <= expect_d;
      s1_fin_q      <= s1_fin_d;
      s1_status_q   <= s1_status_d;
    end
    if (s1_valid_q && s1_adv) begin
      out_byte_q   <= s1_byte;
      byte_valid_q <= s1_emit_q;
      next_need_q  <= s1_need_q;
      finished_q   <= s1_fin_q;
      status_q     <= s1_status_q;
    end
  end

  assign s1_byte = !s1_emit_q ? 8'd0 : (s1_lit_q ? s1_lit_byte_q : hist_rdata);

  // history ring, written as the byte leaves the second stage
  yay0_hist #(
    .Depth(WINDOW_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (s1_valid_q && s1_adv && s1_emit_q),
    .wr_addr_i (s1_waddr_q),
    .wr_data_i (s1_byte),
    .rd_data_o (hist_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign next_need_o  = next_need_q;
  assign finished_o   = finished_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 4;

  typedef enum {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // one input item as it goes on the wire
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } lz_item_t;

  // one predicted result item
  typedef struct packed {
    logic [7:0]      data;
    logic            data_ok;
    yay0_pkg::kind_e need;
    logic            done;
    logic [1:0]      stat;
  } lz_result_t;

  // decoder state kept by the testbench
  typedef struct packed {
    logic [31:0]     flags;
    logic [5:0]      flags_left;
    logic [23:0]     produced;
    logic [8:0]      copy_left;
    logic [12:0]     copy_dist;
    yay0_pkg::kind_e need;
    logic [23:0]     size;
  } lz_state_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [23:0] cfg_size = '0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_value = '0;
  logic        out_ready = 1'b0;

  wire         cfg_ready_o;
  wire         in_ready_o;
  wire         out_valid_o;
  wire  [7:0]  out_byte_o;
  wire         byte_valid_o;
  wire  [2:0]  next_need_o;
  wire         finished_o;
  wire  [1:0]  status_o;

  yay0_lz_decompressor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .out_size_i   (cfg_size),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .kind_i       (in_kind),
    .value_i      (in_value),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .next_need_o  (next_need_o),
    .finished_o   (finished_o),
    .status_o     (status_o)
  );

  // live_st follows accepted items, plan_st follows queued items so the
  // stimulus can be shaped by what the decoder will be waiting for
  lz_state_t   live_st;
  lz_state_t   plan_st;
  logic [7:0]  ring [4096];
  lz_item_t    send_q [$];
  lz_result_t  want_q [$];
  idle_mode_e  idle_mode = IdleNone;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  lz_result_t  drv_res;
  lz_result_t  mon_want;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // pick what comes next once a flag bit is fully handled
  function automatic void settle(inout lz_state_t s);
    s.copy_left = '0;
    s.copy_dist = '0;
    if (s.produced >= s.size) s.need = yay0_pkg::KindStart;
    else if (s.flags_left == 0) s.need = yay0_pkg::KindFlag;
    else if (s.flags[31]) s.need = yay0_pkg::KindChunk;
    else s.need = yay0_pkg::KindLink;
  endfunction

  function automatic void shift_flag(inout lz_state_t s);
    s.flags = s.flags << 1;
    if (s.flags_left != 0) s.flags_left = s.flags_left - 6'd1;
  endfunction

  function automatic void put_byte(inout lz_state_t s, input logic [7:0] b, input bit keep);
    if (keep) ring[s.produced[11:0]] = b;
    s.produced = s.produced + 24'd1;
  endfunction

  // advance the decoder by one item; keep=0 leaves the history ring alone
  function automatic lz_result_t decode_item(inout lz_state_t s, input logic [2:0] k,
                                             input logic [31:0] v, input bit keep);
    lz_result_t  r;
    logic [12:0] span;
    logic [23:0] pos;
    logic [7:0]  b;
    r = '0;
    b = '0;
    if (k == yay0_pkg::KindStart) begin
      s.produced = '0;
      s.flags = '0;
      s.flags_left = '0;
      settle(s);
    end else if (k != s.need) begin
      r.stat = yay0_pkg::StatBadKind;
    end else if (k == yay0_pkg::KindFlag) begin
      s.flags = v;
      s.flags_left = 6'(yay0_pkg::FlagCount);
      settle(s);
    end else if (k == yay0_pkg::KindLink) begin
      span = {1'b0, v[11:0]} + 13'd1;
      if ({11'd0, span} > s.produced) begin
        r.stat = yay0_pkg::StatFar;
      end else begin
        shift_flag(s);
        s.copy_dist = span;
        if (v[15:12] == 4'd0) begin
          s.need = yay0_pkg::KindChunk;
        end else begin
          s.copy_left = {5'd0, v[15:12]} + yay0_pkg::ShortLenBias;
          s.need = yay0_pkg::KindTick;
        end
      end
    end else if (k == yay0_pkg::KindChunk) begin
      if (s.copy_dist != 0) begin
        // zero nibble: this chunk is the length
        s.copy_left = {1'b0, v[7:0]} + yay0_pkg::LongLenBias;
        s.need = yay0_pkg::KindTick;
      end else begin
        b = v[7:0];
        r.data_ok = 1'b1;
        put_byte(s, b, keep);
        shift_flag(s);
        settle(s);
      end
    end else begin
      pos = s.produced - {11'd0, s.copy_dist};
      b = ring[pos[11:0]];
      r.data_ok = 1'b1;
      put_byte(s, b, keep);
      if (s.copy_left != 0) s.copy_left = s.copy_left - 9'd1;
      if (s.produced >= s.size || s.copy_left == 0) settle(s);
    end
    r.data = b;
    r.need = s.need;
    r.done = (s.need == yay0_pkg::KindStart) && (s.produced >= s.size);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued items, predicts each one at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind  <= '0;
      in_value <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        drv_res = decode_item(live_st, in_kind, in_value, 1'b1);
        want_q.push_back(drv_res);
      end
      if (!in_valid || in_ready_o) begin
        if (send_q.size() != 0 &&
            !(idle_mode == IdleSender && $urandom_range(0, 99) < 83) &&
            !(idle_mode == IdleBoth && $urandom_range(0, 99) < 24)) begin
          in_valid <= 1'b1;
          in_kind  <= send_q[0].kind;
          in_value <= send_q[0].value;
          send_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every result item against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    $display("%0t mismatch on %s: got %0h, predicted %0h", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (want_q.size() == 0) begin
          report_mismatch("result with nothing pending", {29'd0, next_need_o}, '0);
        end else begin
          mon_want = want_q.pop_front();
          if (out_byte_o !== mon_want.data)
            report_mismatch("out_byte", 32'(out_byte_o), 32'(mon_want.data));
          if (byte_valid_o !== mon_want.data_ok)
            report_mismatch("byte_valid", 32'(byte_valid_o), 32'(mon_want.data_ok));
          if (next_need_o !== mon_want.need)
            report_mismatch("next_need", 32'(next_need_o), 32'(mon_want.need));
          if (finished_o !== mon_want.done)
            report_mismatch("finished", 32'(finished_o), 32'(mon_want.done));
          if (status_o !== mon_want.stat)
            report_mismatch("status", 32'(status_o), 32'(mon_want.stat));
        end
      end
      if (idle_mode == IdleReceiver) out_ready <= ($urandom_range(0, 99) >= 83);
      else if (idle_mode == IdleBoth) out_ready <= ($urandom_range(0, 99) >= 24);
      else out_ready <= 1'b1;
    end
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [2:0] k, logic [31:0] v);
    lz_result_t unused;
    send_q.push_back('{kind: k, value: v});
    unused = decode_item(plan_st, k, v, 1'b0);
  endtask

  // wait until every queued item went out and every result came back;
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (send_q.size() != 0 || in_valid || want_q.size() != 0);
  endtask

  task automatic set_out_size(logic [23:0] sz);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_size  <= sz;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    live_st.size = sz;
    plan_st.size = sz;
  endtask

  // mostly well-formed items for whatever the decoder waits for, with
  // some noise and some restarts; noise items count only while a tick is expected
  task automatic gen_stream_items(int n);
    int          made;
    int          roll;
    int          p;
    int          span;
    logic [3:0]  nib;
    logic [31:0] v;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(0, 99);
      v = $urandom();
      p = int'(plan_st.produced);
      if (roll < 7) begin
        push_item(3'($urandom_range(1, 7)), v);
        if (plan_st.need == yay0_pkg::KindTick) made++;
      end else if (roll < 9 || plan_st.need == yay0_pkg::KindStart) begin
        push_item(yay0_pkg::KindStart, v);
        made++;
      end else if (plan_st.need == yay0_pkg::KindFlag) begin
        case ($urandom_range(0, 5))
          0: v = '1;
          1: v = '0;
          default: ;
        endcase
        push_item(yay0_pkg::KindFlag, v);
        made++;
      end else if (plan_st.need == yay0_pkg::KindLink) begin
        if (p == 0) begin
          // nothing to refer back to yet: a far link or a restart
          if ($urandom_range(0, 1) == 0) push_item(yay0_pkg::KindStart, v);
          else push_item(yay0_pkg::KindLink, v);
        end else begin
          if (p < 4096 && $urandom_range(0, 9) == 0) span = $urandom_range(4096, p + 1);
          else span = $urandom_range(1, (p < 4096) ? p : 4096);
          nib = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
          v[15:0] = {nib, 12'(span - 1)};
          push_item(yay0_pkg::KindLink, v);
        end
        made++;
      end else if (plan_st.need == yay0_pkg::KindChunk) begin
        // length bytes stay short most of the time
        if (plan_st.copy_dist != 0)
          v[7:0] = ($urandom_range(0, 19) == 0) ? 8'hff : 8'($urandom_range(0, 15));
        push_item(yay0_pkg::KindChunk, v);
        made++;
      end else begin
        push_item(yay0_pkg::KindTick, v);
        made++;
      end
    end
  endtask

  initial begin
    logic [23:0] phase_size [5];
    idle_mode_e  phase_idle [5];
    int          phase_len  [5];
    live_st = '0;
    live_st.need = yay0_pkg::KindStart;
    plan_st = live_st;
    phase_size[0] = 24'd300;
    phase_size[1] = 24'hffffff;
    phase_size[2] = 24'd1;
    phase_size[3] = 24'($urandom_range(50, 250));
    phase_size[4] = 24'($urandom_range(1, 40));
    phase_idle[0] = IdleNone;
    phase_idle[1] = IdleSender;
    phase_idle[2] = IdleReceiver;
    phase_idle[3] = IdleBoth;
    phase_idle[4] = IdleNone;
    phase_len[0] = 90;
    phase_len[1] = 90;
    phase_len[2] = 60;
    phase_len[3] = 90;
    phase_len[4] = 90;

    do @(posedge clk_i);
    while (!rst_n);

    // zero size: start finishes at once, anything else is the wrong kind
    set_out_size(24'd0);
    push_item(yay0_pkg::KindStart, 32'd0);
    push_item(yay0_pkg::KindFlag, 32'hdeadbeef);
    push_item(3'd5, 32'hffffffff);   // kinds past the last code
    push_item(3'd7, 32'h0);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    // short stream: literals, a far link, a short and a long copy, and the
    // size reached in the middle of the long copy
    set_out_size(24'd8);
    push_item(yay0_pkg::KindStart, 32'hffffffff);
    push_item(yay0_pkg::KindLink, 32'h0);          // flag word still expected
    push_item(yay0_pkg::KindFlag, 32'hc0000000);
    push_item(yay0_pkg::KindChunk, 32'h0);
    push_item(yay0_pkg::KindChunk, 32'hffffffff);  // upper bits ignored
    push_item(yay0_pkg::KindLink, 32'h0000ffff);   // distance 4096, far beyond 2
    push_item(yay0_pkg::KindLink, 32'hffff1000);   // distance 1, length 3
    repeat (3) push_item(yay0_pkg::KindTick, 32'h0);
    push_item(yay0_pkg::KindLink, 32'h00000001);   // zero nibble: length from chunk
    push_item(yay0_pkg::KindChunk, 32'h0);         // length 18
    repeat (3) push_item(yay0_pkg::KindTick, $urandom());
    push_item(yay0_pkg::KindTick, 32'hffffffff);   // stream done, start expected
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    for (int ph = 0; ph < 5; ph++) begin
      set_out_size(phase_size[ph]);
      idle_mode = phase_idle[ph];
      if (ph == 3) begin
        // let everything drain once in the middle of a phase
        gen_stream_items(phase_len[ph] / 2);
        wait_drained();
        gen_stream_items(phase_len[ph] - phase_len[ph] / 2);
      end else begin
        gen_stream_items(phase_len[ph]);
      end
      wait_drained();
      idle_mode = IdleNone;
      repeat (DrainCycles) @(posedge clk_i);
    end

    repeat (2 * DrainCycles) @(posedge clk_i);
    if (want_q.size() != 0)
      report_mismatch("results never delivered", 32'(want_q.size()), '0);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
